### src/m3i_pkg.sv
// Shared types, widths and constants for the 3x3 matrix inverse unit.
`default_nettype none

package m3i_pkg;

	localparam int N_EL       = 9;
	localparam int EL_W       = 32;
	localparam int PROD_W     = 64;
	localparam int COF_W      = 65;
	localparam int PP_W       = 65;
	localparam int TERM_W     = 97;
	localparam int DET_W      = 99;
	localparam int MAG_W      = 98;
	localparam int Q_W        = 32;
	localparam int THR_W      = 31;
	localparam int DIV_STAGES = 32;
	// two cofactor stages, five determinant stages, then the divider
	localparam int PIPE_DEPTH = 7 + DIV_STAGES;

	localparam logic [THR_W-1:0] THR_RESET = 31'd1;
	localparam logic [EL_W-1:0]  SAT_POS   = 32'h7FFF_FFFF;
	localparam logic [EL_W-1:0]  SAT_NEG   = 32'h8000_0000;

	typedef logic [EL_W-1:0]  elem_t;
	typedef elem_t [N_EL-1:0] mat_t;
	typedef logic [COF_W-1:0] cof_t;
	typedef cof_t [N_EL-1:0]  cof_vec_t;
	typedef logic [MAG_W-1:0] mag_t;
	typedef mag_t [N_EL-1:0]  mag_vec_t;
	typedef logic [Q_W-1:0]   quo_t;
	typedef quo_t [N_EL-1:0]  quo_vec_t;

	// cofactor k = m[a]*m[b] - m[c]*m[d], flat index column*3 + row
	typedef logic [0:3][3:0] idx_row_t;
	localparam idx_row_t COF_IDX [N_EL] = '{
		'{4'd4, 4'd8, 4'd5, 4'd7}, '{4'd2, 4'd7, 4'd1, 4'd8}, '{4'd1, 4'd5, 4'd2, 4'd4},
		'{4'd5, 4'd6, 4'd3, 4'd8}, '{4'd0, 4'd8, 4'd2, 4'd6}, '{4'd2, 4'd3, 4'd0, 4'd5},
		'{4'd3, 4'd7, 4'd4, 4'd6}, '{4'd1, 4'd6, 4'd0, 4'd7}, '{4'd0, 4'd4, 4'd1, 4'd3}
	};

	// sideband carried alongside the divider lanes
	typedef struct packed {
		mat_t              m;
		logic              sing;
		logic [N_EL-1:0]   neg;
		logic [N_EL-1:0]   ovf;
	} side_t;

	typedef struct packed {
		logic signed [EL_W-1:0] in_c0_r0;
		logic signed [EL_W-1:0] in_c0_r1;
		logic signed [EL_W-1:0] in_c0_r2;
		logic signed [EL_W-1:0] in_c1_r0;
		logic signed [EL_W-1:0] in_c1_r1;
		logic signed [EL_W-1:0] in_c1_r2;
		logic signed [EL_W-1:0] in_c2_r0;
		logic signed [EL_W-1:0] in_c2_r1;
		logic signed [EL_W-1:0] in_c2_r2;
	} in_data_t;

	typedef struct packed {
		logic signed [EL_W-1:0] out_c0_r0;
		logic signed [EL_W-1:0] out_c0_r1;
		logic signed [EL_W-1:0] out_c0_r2;
		logic signed [EL_W-1:0] out_c1_r0;
		logic signed [EL_W-1:0] out_c1_r1;
		logic signed [EL_W-1:0] out_c1_r2;
		logic signed [EL_W-1:0] out_c2_r0;
		logic signed [EL_W-1:0] out_c2_r1;
		logic signed [EL_W-1:0] out_c2_r2;
		logic                   invertible;
	} out_data_t;

endpackage

`default_nettype wire

### src/m3i_cofactor.sv
// Two-stage cofactor lanes: 2x2 products, then their exact differences.
`default_nettype none

module m3i_cofactor (
	input  wire logic            clk,
	input  wire logic            en,
	input  wire m3i_pkg::mat_t   m,
	output m3i_pkg::mat_t        m_out,
	output m3i_pkg::cof_vec_t    cof_out
);
	import m3i_pkg::*;

	logic signed [PROD_W-1:0] pa_s1 [N_EL];
	logic signed [PROD_W-1:0] pb_s1 [N_EL];
	mat_t                     m_s1;
	cof_vec_t                 cof_s2;
	mat_t                     m_s2;

	// stage 1: two signed 32x32 products per lane
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < N_EL; k++) begin
				pa_s1[k] <= $signed(m[COF_IDX[k][0]]) * $signed(m[COF_IDX[k][1]]);
				pb_s1[k] <= $signed(m[COF_IDX[k][2]]) * $signed(m[COF_IDX[k][3]]);
			end
			m_s1 <= m;
		end
	end

	// stage 2: exact difference, one bit wider
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < N_EL; k++) begin
				cof_s2[k] <= $signed({pa_s1[k][PROD_W-1], pa_s1[k]})
					- $signed({pb_s1[k][PROD_W-1], pb_s1[k]});
			end
			m_s2 <= m_s1;
		end
	end

	assign m_out   = m_s2;
	assign cof_out = cof_s2;

endmodule

`default_nettype wire

### src/m3i_det.sv
// Determinant along the first column, magnitudes and singular/overflow checks.
`default_nettype none

module m3i_det (
	input  wire logic                       clk,
	input  wire logic                       en,
	input  wire m3i_pkg::mat_t              m,
	input  wire m3i_pkg::cof_vec_t          cof,
	input  wire logic [m3i_pkg::THR_W-1:0]  thr,
	output m3i_pkg::mag_vec_t               rem_out,
	output m3i_pkg::mag_t                   den_out,
	output m3i_pkg::side_t                  side_out
);
	import m3i_pkg::*;

	logic signed [PP_W-1:0]   ph_s3 [3];
	logic signed [PP_W-1:0]   pl_s3 [3];
	cof_vec_t                 cof_s3, cof_s4, cof_s5;
	mat_t                     m_s3, m_s4, m_s5, m_s6;
	logic signed [TERM_W-1:0] term_s4 [3];
	logic signed [DET_W-1:0]  det_s5;
	logic [DET_W-1:0]         det_neg_v;
	mag_t                     adet_s6;
	logic                     det_neg_s6;
	logic [COF_W-1:0]         cabs_s6 [N_EL];
	logic [N_EL-1:0]          cneg_s6;
	mag_vec_t                 rem_s7;
	mag_t                     den_s7;
	side_t                    side_s7;

	// stage 3: element times cofactor, cofactor split in high and low halves
	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 3; j++) begin
				ph_s3[j] <= $signed(m[j]) * $signed(cof[3*j][COF_W-1:32]);
				pl_s3[j] <= $signed(m[j]) * $signed({1'b0, cof[3*j][31:0]});
			end
			cof_s3 <= cof;
			m_s3   <= m;
		end
	end

	// stage 4: recombine halves into full terms
	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 3; j++) begin
				term_s4[j] <= $signed({ph_s3[j], 32'd0})
					+ $signed({{32{pl_s3[j][PP_W-1]}}, pl_s3[j]});
			end
			cof_s4 <= cof_s3;
			m_s4   <= m_s3;
		end
	end

	// stage 5: sum of the three terms
	always_ff @(posedge clk) begin
		if (en) begin
			det_s5 <= $signed({{2{term_s4[0][TERM_W-1]}}, term_s4[0]})
				+ $signed({{2{term_s4[1][TERM_W-1]}}, term_s4[1]})
				+ $signed({{2{term_s4[2][TERM_W-1]}}, term_s4[2]});
			cof_s5 <= cof_s4;
			m_s5   <= m_s4;
		end
	end

	assign det_neg_v = DET_W'(0) - det_s5;

	// stage 6: magnitudes and signs
	always_ff @(posedge clk) begin
		if (en) begin
			det_neg_s6 <= det_s5[DET_W-1];
			adet_s6    <= det_s5[DET_W-1] ? det_neg_v[MAG_W-1:0] : det_s5[MAG_W-1:0];
			for (int k = 0; k < N_EL; k++) begin
				cneg_s6[k] <= cof_s5[k][COF_W-1];
				cabs_s6[k] <= cof_s5[k][COF_W-1] ? (COF_W'(0) - cof_s5[k]) : cof_s5[k];
			end
			m_s6 <= m_s5;
		end
	end

	// stage 7: singular test, quotient overflow per lane, divider operands
	always_ff @(posedge clk) begin
		if (en) begin
			side_s7.sing <= (adet_s6 == '0)
				|| (adet_s6[MAG_W-1:32] < {{(MAG_W-32-THR_W){1'b0}}, thr});
			for (int k = 0; k < N_EL; k++) begin
				side_s7.ovf[k] <= {{(MAG_W-COF_W){1'b0}}, cabs_s6[k]} >= adet_s6;
				side_s7.neg[k] <= cneg_s6[k] ^ det_neg_s6;
				rem_s7[k]      <= {{(MAG_W-COF_W){1'b0}}, cabs_s6[k]};
			end
			side_s7.m <= m_s6;
			den_s7    <= adet_s6;
		end
	end

	assign rem_out  = rem_s7;
	assign den_out  = den_s7;
	assign side_out = side_s7;

endmodule

`default_nettype wire

### src/m3i_divider.sv
// Nine restoring-division lanes, one quotient bit per stage, sharing the divisor.
`default_nettype none

module m3i_divider (
	input  wire logic                clk,
	input  wire logic                en,
	input  wire m3i_pkg::mag_vec_t   rem_in,
	input  wire m3i_pkg::mag_t       den_in,
	input  wire m3i_pkg::side_t      side_in,
	output m3i_pkg::quo_vec_t        q_out,
	output m3i_pkg::side_t           side_out
);
	import m3i_pkg::*;

	mag_vec_t rem_q  [DIV_STAGES];
	quo_vec_t quo_q  [DIV_STAGES];
	mag_t     den_q  [DIV_STAGES];
	side_t    side_q [DIV_STAGES];

	for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
		mag_vec_t rem_src, rem_nxt;
		quo_vec_t quo_src, quo_nxt;
		mag_t     den_src;
		side_t    side_src;

		if (s == 0) begin : g_first
			assign rem_src  = rem_in;
			assign quo_src  = '0;
			assign den_src  = den_in;
			assign side_src = side_in;
		end else begin : g_next
			assign rem_src  = rem_q[s-1];
			assign quo_src  = quo_q[s-1];
			assign den_src  = den_q[s-1];
			assign side_src = side_q[s-1];
		end

		// shift, trial subtract, keep the difference if it fits
		always_comb begin
			logic [MAG_W:0] sh_v;
			logic [MAG_W:0] diff_v;
			logic           ge_v;
			for (int k = 0; k < N_EL; k++) begin
				sh_v       = {rem_src[k], 1'b0};
				diff_v     = sh_v - {1'b0, den_src};
				ge_v       = sh_v >= {1'b0, den_src};
				rem_nxt[k] = ge_v ? diff_v[MAG_W-1:0] : sh_v[MAG_W-1:0];
				quo_nxt[k] = {quo_src[k][Q_W-2:0], ge_v};
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[s]  <= rem_nxt;
				quo_q[s]  <= quo_nxt;
				den_q[s]  <= den_src;
				side_q[s] <= side_src;
			end
		end
	end

	assign q_out    = quo_q[DIV_STAGES-1];
	assign side_out = side_q[DIV_STAGES-1];

endmodule

`default_nettype wire

### src/matrix3_inverse_unit.sv
// Top level of the 3x3 matrix inverse unit: handshake, pipeline control, result merge.
// Inverts one 3x3 Q16.16 matrix per clock cycle by the adjugate method while
// the output side does not stall. An accepted matrix passes through the
// cofactor product stages, the determinant and range-check stages, the
// per-lane restoring divider (one quotient bit per stage, nine lanes side by
// side) and the output register. A stall on out_ready holds the whole
// pipeline, so in_ready follows out_ready whenever a result is waiting. A
// matrix whose truncated determinant magnitude is below the threshold written
// through cfg_data (or is zero) comes back unchanged with invertible low. The
// threshold port is always ready; write it only while no matrix is in flight.
`default_nettype none

module matrix3_inverse_unit (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire m3i_pkg::in_data_t          in_data,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output m3i_pkg::out_data_t              out_data,
	input  wire logic                       cfg_valid,
	output logic                            cfg_ready,
	input  wire logic [m3i_pkg::THR_W-1:0]  cfg_data
);
	import m3i_pkg::*;

	logic [THR_W-1:0]      thr_q;
	logic                  adv;
	logic [PIPE_DEPTH-1:0] vld_q;
	logic                  out_valid_q;
	out_data_t             out_data_q;
	mat_t                  mat_in;
	mat_t                  m_cof;
	cof_vec_t              cof;
	mag_vec_t              rem0;
	mag_t                  den0;
	side_t                 side_det;
	quo_vec_t              quo;
	side_t                 side_div;
	elem_t                 res [N_EL];

	// threshold register
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
		end else if (cfg_valid && cfg_ready) begin
			thr_q <= cfg_data;
		end
	end

	// whole pipeline moves when the output register is free or being drained
	assign adv      = out_ready || !out_valid_q;
	assign in_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			vld_q       <= {vld_q[PIPE_DEPTH-2:0], in_valid};
			out_valid_q <= vld_q[PIPE_DEPTH-1];
		end
	end

	assign mat_in[0] = in_data.in_c0_r0;
	assign mat_in[1] = in_data.in_c0_r1;
	assign mat_in[2] = in_data.in_c0_r2;
	assign mat_in[3] = in_data.in_c1_r0;
	assign mat_in[4] = in_data.in_c1_r1;
	assign mat_in[5] = in_data.in_c1_r2;
	assign mat_in[6] = in_data.in_c2_r0;
	assign mat_in[7] = in_data.in_c2_r1;
	assign mat_in[8] = in_data.in_c2_r2;

	m3i_cofactor u_cofactor (
		.clk     (clk),
		.en      (adv),
		.m       (mat_in),
		.m_out   (m_cof),
		.cof_out (cof)
	);

	m3i_det u_det (
		.clk      (clk),
		.en       (adv),
		.m        (m_cof),
		.cof      (cof),
		.thr      (thr_q),
		.rem_out  (rem0),
		.den_out  (den0),
		.side_out (side_det)
	);

	m3i_divider u_divider (
		.clk      (clk),
		.en       (adv),
		.rem_in   (rem0),
		.den_in   (den0),
		.side_in  (side_det),
		.q_out    (quo),
		.side_out (side_div)
	);

	// merge: sign, saturation, or pass-through for a singular matrix
	always_comb begin
		for (int k = 0; k < N_EL; k++) begin
			if (side_div.sing) begin
				res[k] = side_div.m[k];
			end else if (!side_div.neg[k]) begin
				res[k] = (side_div.ovf[k] || quo[k][Q_W-1]) ? SAT_POS : quo[k];
			end else begin
				res[k] = (side_div.ovf[k] || (quo[k] > SAT_NEG)) ? SAT_NEG
					: (EL_W'(0) - quo[k]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_data_q.out_c0_r0  <= res[0];
			out_data_q.out_c0_r1  <= res[1];
			out_data_q.out_c0_r2  <= res[2];
			out_data_q.out_c1_r0  <= res[3];
			out_data_q.out_c1_r1  <= res[4];
			out_data_q.out_c1_r2  <= res[5];
			out_data_q.out_c2_r0  <= res[6];
			out_data_q.out_c2_r1  <= res[7];
			out_data_q.out_c2_r2  <= res[8];
			out_data_q.invertible <= !side_div.sing;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// a stalled pipeline keeps its occupancy
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(vld_q))
		else $error("pipeline occupancy changed during a stall");

	// the last stage's item reaches the output register on an advance
	a_last_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		adv && vld_q[PIPE_DEPTH-1] |=> out_valid)
		else $error("finished item lost before the output register");

	// a bubble in the last stage leaves the output empty
	a_bubble_out: assert property (@(posedge clk) disable iff (!arst_n)
		adv && !vld_q[PIPE_DEPTH-1] |=> !out_valid)
		else $error("result invented from an empty stage");

endmodule

`default_nettype wire
